/* rtl/core/lss_pkg.sv */
// ----------------------------------------------------------------------------
// lss_pkg
// shared constants for the life stencil stream block
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int DIM_MIN     = 3;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PADDED_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PADDED_HEIGHT = CFG_INDEX_W'(1);

  // rule constants
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

/* rtl/core/lss_cell_if.sv */
// ----------------------------------------------------------------------------
// lss_cell_if
// input beat channel: one padded grid cell per beat
// ----------------------------------------------------------------------------
interface lss_cell_if;
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink   (input valid, input cell_alive, output ready);
endinterface

/* rtl/core/lss_result_if.sv */
// ----------------------------------------------------------------------------
// lss_result_if
// output beat channel: next state of one interior cell per beat
// ----------------------------------------------------------------------------
interface lss_result_if;
  logic valid;
  logic ready;
  logic next_alive;
  logic row_end;
  logic frame_end;

  modport source (output valid, output next_alive, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input next_alive, input row_end, input frame_end,
                  output ready);
endinterface

/* rtl/core/life_stencil_stream.sv */
// ----------------------------------------------------------------------------
// life_stencil_stream
// game of life generation step (B3/S23) on a streamed padded grid
// ----------------------------------------------------------------------------
// a cell beat is registered in stage 1, then its result in the output register
// throughput: one cell per cycle while the output register is not stalled, set
//   by the single read and write port of the line store memory (read at
//   accept, write back when the beat leaves stage 1)
// halo cells give no result beat, interior cells give exactly one
// reset clears the raster counters, the window and all valid flags; the line
//   store memory is not cleared, no clearing pass is run
// ----------------------------------------------------------------------------
module life_stencil_stream (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lss_pkg::CFG_DATA_W-1:0]    cfg_data,
  lss_cell_if.sink                          cells,
  lss_result_if.source                      results
);

  // configuration registers
  logic [lss_pkg::CFG_DATA_W-1:0] padded_width;
  logic [lss_pkg::CFG_DATA_W-1:0] padded_height;
  logic                           cfg_hit;

  // clamped last column and last row of the padded grid
  logic [lss_pkg::COL_W-1:0] col_last;
  logic [lss_pkg::ROW_W-1:0] row_last;

  // raster position of the next input beat
  logic [lss_pkg::COL_W-1:0] col;
  logic [lss_pkg::ROW_W-1:0] row;
  logic [lss_pkg::COL_W-1:0] col_next;
  logic [lss_pkg::ROW_W-1:0] row_next;

  // line store memory: bit 1 holds the row above, bit 0 the row two above
  logic [1:0] line_mem [lss_pkg::MAX_WIDTH];
  logic [1:0] line_rdata;

  // stage 1: cell waiting for its line store data
  logic                      s1_valid;
  logic                      s1_cell;
  logic [lss_pkg::COL_W-1:0] s1_col;
  logic                      s1_interior;
  logic                      s1_row_end;
  logic                      s1_frame_end;

  // 3x3 window, newest column in the low bits
  logic [8:0] window;
  logic [8:0] window_next;
  logic       centre;
  logic [3:0] neighbours;
  logic       alive;

  logic in_accept;
  logic s1_adv;
  logic out_free;
  logic at_row_end;

  // ---------------------------------------------------------------------------
  // dimension clamp: below the minimum acts as the minimum, above the maximum
  // acts as the maximum
  // ---------------------------------------------------------------------------
  always_comb begin
    if (padded_width < lss_pkg::DIM_MIN) begin
      col_last = lss_pkg::COL_W'(lss_pkg::DIM_MIN - 1);
    end else if (padded_width > lss_pkg::MAX_WIDTH) begin
      col_last = lss_pkg::COL_W'(lss_pkg::MAX_WIDTH - 1);
    end else begin
      col_last = lss_pkg::COL_W'(padded_width - 1'b1);
    end
    if (padded_height < lss_pkg::DIM_MIN) begin
      row_last = lss_pkg::ROW_W'(lss_pkg::DIM_MIN - 1);
    end else if (padded_height > lss_pkg::MAX_HEIGHT) begin
      row_last = lss_pkg::ROW_W'(lss_pkg::MAX_HEIGHT - 1);
    end else begin
      row_last = lss_pkg::ROW_W'(padded_height - 1'b1);
    end
  end

  // any write to a listed register restarts the frame
  assign cfg_hit = cfg_we &&
                   (cfg_index == lss_pkg::REG_PADDED_WIDTH ||
                    cfg_index == lss_pkg::REG_PADDED_HEIGHT);

  // ---------------------------------------------------------------------------
  // handshake: the output register parts the two sides; stage 1 moves on when
  // the output slot is empty or being drained this cycle
  // ---------------------------------------------------------------------------
  assign out_free  = !results.valid || results.ready;
  assign s1_adv    = s1_valid && out_free;
  assign cells.ready = !s1_valid || out_free;
  assign in_accept = cells.valid && cells.ready;

  // raster counter wrap
  assign at_row_end = (col == col_last);
  always_comb begin
    col_next = col + 1'b1;
    row_next = row;
    if (at_row_end) begin
      col_next = '0;
      row_next = (row == row_last) ? '0 : row + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      padded_width  <= lss_pkg::CFG_DATA_W'(lss_pkg::MAX_WIDTH);
      padded_height <= lss_pkg::CFG_DATA_W'(lss_pkg::MAX_HEIGHT);
      col <= '0;
      row <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == lss_pkg::REG_PADDED_WIDTH) begin
        padded_width <= cfg_data;
      end else begin
        padded_height <= cfg_data;
      end
      col <= '0;
      row <= '0;
    end else if (in_accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // ---------------------------------------------------------------------------
  // line store memory: read at accept, write back when stage 1 moves on.
  // a column comes around only once per clamped row, so outside a restart the
  // write of one cell never meets the read of the next one at the same entry
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      line_rdata <= line_mem[col];
    end
    if (s1_adv) begin
      // row above moves up, current cell becomes the row above
      line_mem[s1_col] <= {s1_cell, line_rdata[1]};
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_cell      <= cells.cell_alive;
      s1_col       <= col;
      s1_interior  <= (row >= lss_pkg::ROW_W'(2)) && (col >= lss_pkg::COL_W'(2));
      s1_row_end   <= at_row_end;
      s1_frame_end <= at_row_end && (row == row_last);
    end
  end

  // ---------------------------------------------------------------------------
  // window shift and the B3/S23 rule
  // ---------------------------------------------------------------------------
  assign window_next = {window[5:0], s1_cell, line_rdata[1], line_rdata[0]};
  assign centre      = window_next[4];
  assign neighbours  = 4'($countones(window_next)) - {3'b000, centre};
  assign alive       = (neighbours == lss_pkg::BIRTH_COUNT) ||
                       ((neighbours == lss_pkg::SURVIVE_COUNT) && centre);

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (cfg_hit) begin
      window <= '0;
    end else if (s1_adv) begin
      window <= window_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (s1_adv) begin
      results.valid <= s1_interior;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
    if (s1_adv && s1_interior) begin
      results.next_alive <= alive;
      results.row_end    <= s1_row_end;
      results.frame_end  <= s1_frame_end;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_no_s1_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !in_accept)
    else $error("stage 1 overwritten while stalled");

  a_no_mem_collision: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && in_accept) |-> (col != s1_col))
    else $error("line store read and write hit the same entry");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col <= col_last)
    else $error("column counter beyond padded width");

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (!results.frame_end || results.row_end))
    else $error("frame end without row end");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (col == '0 && row == '0 && !s1_valid && !results.valid))
    else $error("reset did not clear control state");

endmodule

/* dv/life_stencil_stream_tb.sv */
// ----------------------------------------------------------------------------
// life_stencil_stream_tb
// self-checking bench for the B3/S23 stencil stream: every cell beat is run
// through a cycle-free next-state predictor, and every result beat is checked
// against the oldest predicted state in order, with random idling on both sides
// ----------------------------------------------------------------------------
module life_stencil_stream_tb;

  localparam int RANDOM_CELLS = 950;
  localparam int STALL_LIMIT  = 1000;
  localparam int SETTLE_WAIT  = 4;
  localparam int HALO_BURST   = 24;

  // 3x3 frames, raster order, first cell in bit 0
  localparam logic [8:0] BIRTH_FRAME   = 9'b000_000_111;  // dead centre, top row alive
  localparam logic [8:0] SURVIVE_FRAME = 9'b100_010_001;  // live centre, two corners
  localparam logic [8:0] CROWD_FRAME   = 9'b111_111_111;  // live centre, eight neighbours

  typedef struct packed {
    logic next_alive;
    logic row_end;
    logic frame_end;
  } life_result_t;

  // next-state predictor plus the in-order store of predicted result beats
  class generation_scoreboard;
    logic [lss_pkg::CFG_DATA_W-1:0] width_reg;
    logic [lss_pkg::CFG_DATA_W-1:0] height_reg;
    bit                             upper_row [lss_pkg::MAX_WIDTH];
    bit                             middle_row[lss_pkg::MAX_WIDTH];
    logic [8:0]                     window;
    int unsigned                    col_pos;
    int unsigned                    row_pos;
    life_result_t                   next_states[$];
    int unsigned                    errors;
    int unsigned                    checked;
    int unsigned                    cells_seen;

    function new();
      width_reg  = lss_pkg::CFG_DATA_W'(lss_pkg::MAX_WIDTH);
      height_reg = lss_pkg::CFG_DATA_W'(lss_pkg::MAX_HEIGHT);
      window     = '0;
      col_pos    = 0;
      row_pos    = 0;
      errors     = 0;
      checked    = 0;
      cells_seen = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned raw, int unsigned top);
      if (raw < lss_pkg::DIM_MIN) return lss_pkg::DIM_MIN;
      if (raw > top) return top;
      return raw;
    endfunction

    function int unsigned active_cols();
      return clamp_dim(32'(width_reg), lss_pkg::MAX_WIDTH);
    endfunction

    function int unsigned active_rows();
      return clamp_dim(32'(height_reg), lss_pkg::MAX_HEIGHT);
    endfunction

    // either register restarts the frame, other indexes are ignored
    function void write_reg(logic [lss_pkg::CFG_INDEX_W-1:0] idx,
                            logic [lss_pkg::CFG_DATA_W-1:0] data);
      if (idx == lss_pkg::REG_PADDED_WIDTH) width_reg = data;
      else if (idx == lss_pkg::REG_PADDED_HEIGHT) height_reg = data;
      else return;
      window  = '0;
      col_pos = 0;
      row_pos = 0;
    endfunction

    function void note_cell(logic alive);
      int unsigned  w;
      int unsigned  h;
      int unsigned  nb;
      bit           up2;
      bit           up1;
      logic         centre;
      life_result_t want;
      w = active_cols();
      h = active_rows();
      cells_seen++;
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      up2 = upper_row[col_pos];
      up1 = middle_row[col_pos];
      upper_row[col_pos]  = up1;
      middle_row[col_pos] = alive;
      window = {window[5:0], alive, up1, up2};
      if (row_pos >= 2 && col_pos >= 2) begin
        centre          = window[4];
        nb              = $countones(window) - centre;
        want.next_alive = (nb == 3) || (nb == 2 && centre);
        want.row_end    = (col_pos == w - 1);
        want.frame_end  = want.row_end && (row_pos == h - 1);
        next_states.push_back(want);
      end
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
      end
    endfunction

    function void check_result(life_result_t got);
      life_result_t want;
      if (next_states.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing predicted, expected none, got %b",
                 $time, got);
        return;
      end
      want = next_states.pop_front();
      checked++;
      compare_field("next_alive", want.next_alive, got.next_alive);
      compare_field("row_end", want.row_end, got.row_end);
      compare_field("frame_end", want.frame_end, got.frame_end);
    endfunction

    function int unsigned pending();
      return next_states.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [lss_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lss_pkg::CFG_DATA_W-1:0]  cfg_data;

  lss_cell_if   cells();
  lss_result_if results();

  generation_scoreboard sb = new();

  bit          smooth = 1'b0;   // phase with no idling on either side
  int unsigned rx_hold = 0;
  int unsigned cfg_writes = 0;

  life_stencil_stream DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (cells),
    .results   (results)
  );

  always #5 clk = ~clk;

  // mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // sink side: random stalls on the result channel
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      results.ready <= 1'b0;
      rx_hold--;
    end else begin
      results.ready <= 1'b1;
      if (!smooth && $urandom_range(0, 1) == 0) rx_hold = pick_gap();
    end
  end

  // monitor: results are checked before the same edge's cell is predicted,
  // a result always belongs to an older cell
  always @(posedge clk) begin
    if (!rst) begin
      if (results.valid && results.ready)
        sb.check_result(life_result_t'{results.next_alive, results.row_end,
                                       results.frame_end});
      if (cells.valid && cells.ready) sb.note_cell(cells.cell_alive);
    end
  end

  // watchdog: ends the run when no beat moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cells.valid && cells.ready) || (results.valid && results.ready) || rst)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // one cell beat; valid stays high across back-to-back beats
  task automatic send_cell(logic alive);
    int unsigned gap;
    gap = smooth ? 0 : pick_gap();
    if (gap > 0) begin
      cells.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cells.valid      <= 1'b1;
    cells.cell_alive <= alive;
    do @(posedge clk); while (!cells.ready);
  endtask

  task automatic send_frame(logic [8:0] pattern);
    for (int i = 0; i < 9; i++) send_cell(pattern[i]);
  endtask

  // stop sending, wait for every predicted beat, then let halo cells that
  // gave no result leave the pipeline
  task automatic drain_results();
    cells.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic cfg_beat(logic [lss_pkg::CFG_INDEX_W-1:0] idx,
                          logic [lss_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    cfg_writes++;
    @(posedge clk);
  endtask

  // register writes only while the block is idle; a write to an unused
  // index follows every time and must change nothing
  task automatic program_grid(logic [lss_pkg::CFG_DATA_W-1:0] raw_w,
                              logic [lss_pkg::CFG_DATA_W-1:0] raw_h,
                              bit do_w, bit do_h);
    if (do_w) cfg_beat(lss_pkg::REG_PADDED_WIDTH, raw_w);
    if (do_h) cfg_beat(lss_pkg::REG_PADDED_HEIGHT, raw_h);
    cfg_beat(lss_pkg::CFG_INDEX_W'($urandom_range(lss_pkg::REG_PADDED_HEIGHT + 1,
                                                   2**lss_pkg::CFG_INDEX_W - 1)),
             lss_pkg::CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned                    rand_cells;
    int unsigned                    frame;
    int unsigned                    count;
    int unsigned                    density;
    int unsigned                    pick;
    logic [lss_pkg::CFG_DATA_W-1:0] raw_w;
    logic [lss_pkg::CFG_DATA_W-1:0] raw_h;

    cells.valid      <= 1'b0;
    cells.cell_alive <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    rst              <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset geometry is the largest one: a short burst stays in the halo
    // rows and gives no result
    repeat (HALO_BURST) send_cell(1'($urandom_range(0, 1)));
    drain_results();

    // smallest grid, one interior cell per frame: birth, survival
    program_grid(lss_pkg::CFG_DATA_W'(lss_pkg::DIM_MIN),
                 lss_pkg::CFG_DATA_W'(lss_pkg::DIM_MIN), 1'b1, 1'b1);
    send_frame(BIRTH_FRAME);
    send_frame(SURVIVE_FRAME);
    drain_results();

    // values under the minimum act as the minimum; overcrowded centre dies
    program_grid('0, lss_pkg::CFG_DATA_W'(lss_pkg::DIM_MIN - 1), 1'b1, 1'b1);
    send_frame(CROWD_FRAME);
    drain_results();

    // all data bits set: width beyond the maximum acts as the maximum, so a
    // short burst gives no result
    program_grid('1, lss_pkg::CFG_DATA_W'(lss_pkg::DIM_MIN), 1'b1, 1'b1);
    repeat (HALO_BURST) send_cell(1'($urandom_range(0, 1)));
    drain_results();

    // height just over the maximum acts as the maximum: no early frame end
    program_grid(lss_pkg::CFG_DATA_W'(lss_pkg::DIM_MIN),
                 lss_pkg::CFG_DATA_W'(lss_pkg::MAX_HEIGHT + 1), 1'b1, 1'b1);
    repeat (HALO_BURST) send_cell(1'($urandom_range(0, 1)));
    drain_results();

    // random phases: small grids, random fill density, frames back to
    // back, phases ending mid-frame so that later writes restart the raster
    rand_cells = 0;
    while (rand_cells < RANDOM_CELLS) begin
      smooth = ($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 9);
      raw_w  = ($urandom_range(0, 4) == 0)
               ? lss_pkg::CFG_DATA_W'($urandom_range(0, lss_pkg::DIM_MIN - 1))
               : lss_pkg::CFG_DATA_W'($urandom_range(lss_pkg::DIM_MIN, 14));
      raw_h  = ($urandom_range(0, 4) == 0)
               ? lss_pkg::CFG_DATA_W'($urandom_range(0, lss_pkg::DIM_MIN - 1))
               : lss_pkg::CFG_DATA_W'($urandom_range(lss_pkg::DIM_MIN, 10));
      if (pick < 7) program_grid(raw_w, raw_h, 1'b1, 1'b1);
      else if (pick == 7) program_grid(raw_w, raw_h, 1'b1, 1'b0);
      else if (pick == 8) program_grid(raw_w, raw_h, 1'b0, 1'b1);
      // otherwise the raster carries on where the last phase paused
      frame   = sb.active_cols() * sb.active_rows();
      count   = $urandom_range(frame / 2, 2 * frame);
      density = $urandom_range(1, 3);
      repeat (count) send_cell($urandom_range(0, 3) < density);
      rand_cells += count;
      drain_results();
    end
    smooth = 1'b0;

    $display("streamed %0d cells over %0d register writes, %0d next-state beats checked",
             sb.cells_seen, cfg_writes, sb.checked);
    $display("grids from 3x3 to 14x10, sizes clamped at both ends, restarts mid-frame");
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/lss_pkg.sv
rtl/core/lss_cell_if.sv
rtl/core/lss_result_if.sv
rtl/core/life_stencil_stream.sv
dv/life_stencil_stream_tb.sv
